### hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Default width of the hue fraction; 2^HUE_BITS is one full turn.
    localparam int HUE_BITS_DEFAULT = 16;

    // Reciprocal of 255 scaled by 2^23; exact for every 16-bit dividend.
    localparam logic [15:0] DIV255_RECIP = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    // Hue sectors, named after the two colors they run between.
    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

endpackage

### hdl/hsv_to_rgb_pixel_unit.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter.
// The s_ channel carries one pixel word per handshake: hue (HUE_BITS bits, a
// fraction of a full turn), saturation and value (8 bits each, 255 is one).
// The m_ channel returns one word per input word with red, green and blue.
// The datapath is a four-stage pipeline: hue sector and fraction, the
// saturation products, the value products, then the divide by 255 and the
// channel ordering into the output register. An accepted word moves through
// the stage registers in order and waits in its stage while the stage after
// it cannot move. Throughput is one word per clock cycle while the receiver
// keeps m_tready high; the rate is set by the pipeline, where every stage
// holds one word and each multiplier is registered.
// A stall on m_tready holds the output word; the stages behind it keep
// filling any empty slots, and s_tready drops only when every stage is full.
// A synchronous active-low reset clears all valid bits, so the pipeline comes
// up empty; the data registers are not reset.
// The block keeps no state between words.
module hsv_to_rgb_pixel_unit
    import hsvrgb_pkg::*;
#(
    parameter int HUE_BITS = HUE_BITS_DEFAULT,
    localparam int IN_W    = ((HUE_BITS + 16 + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // s_tdata fields from bit 0 up: hue, saturation, brightness, zero pad.
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    // m_tdata fields from bit 0 up: red, green, blue.
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata
);

    // Fixed-point constants: one turn, and 255 in the same scale.
    localparam logic [HUE_BITS:0]   HUE_ONE    = {1'b1, {HUE_BITS{1'b0}}};
    localparam logic [HUE_BITS+7:0] FULL_SCALE = {8'hFF, {HUE_BITS{1'b0}}};

    // Input field split.
    logic [HUE_BITS-1:0] in_hue;
    logic [7:0]          in_sat;
    logic [7:0]          in_bri;

    assign in_hue = s_tdata[HUE_BITS-1:0];
    assign in_sat = s_tdata[HUE_BITS+7:HUE_BITS];
    assign in_bri = s_tdata[HUE_BITS+15:HUE_BITS+8];

    // Stage enables: a stage moves when it is empty or the one after it moves.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: hue times six gives the sector in the top bits and the
    // fraction below. The p product bri * (255 - sat) is formed here too.
    logic [HUE_BITS+2:0] hue6;
    sector_t             s1_sector_reg, s1_sector_next;
    logic [HUE_BITS-1:0] s1_frac_reg, s1_frac_next;
    logic [7:0]          s1_sat_reg, s1_bri_reg;
    logic [15:0]         s1_pprod_reg, s1_pprod_next;

    always_comb begin
        hue6           = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};
        s1_sector_next = sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
        s1_frac_next   = hue6[HUE_BITS-1:0];
        s1_pprod_next  = {8'b0, in_bri} * {8'b0, 8'hFF - in_sat};
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_sector_reg <= s1_sector_next;
            s1_frac_reg   <= s1_frac_next;
            s1_sat_reg    <= in_sat;
            s1_bri_reg    <= in_bri;
            s1_pprod_reg  <= s1_pprod_next;
        end
    end

    // Stage 2: numerators 255*2^H - f*s for q and 255*2^H - (2^H - f)*s for t.
    logic [HUE_BITS:0]   one_minus_f;
    logic [HUE_BITS+7:0] fs_prod, gs_prod;
    logic [HUE_BITS+7:0] s2_nq_reg, s2_nq_next, s2_nt_reg, s2_nt_next;
    sector_t             s2_sector_reg;
    logic [7:0]          s2_bri_reg;
    logic [15:0]         s2_pprod_reg;

    always_comb begin
        one_minus_f = HUE_ONE - {1'b0, s1_frac_reg};
        fs_prod     = {8'b0, s1_frac_reg} * {{HUE_BITS{1'b0}}, s1_sat_reg};
        gs_prod     = {7'b0, one_minus_f} * {{HUE_BITS{1'b0}}, s1_sat_reg};
        s2_nq_next  = FULL_SCALE - fs_prod;
        s2_nt_next  = FULL_SCALE - gs_prod;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_nq_reg     <= s2_nq_next;
            s2_nt_reg     <= s2_nt_next;
            s2_sector_reg <= s1_sector_reg;
            s2_bri_reg    <= s1_bri_reg;
            s2_pprod_reg  <= s1_pprod_reg;
        end
    end

    // Stage 3: scale by value and drop the fraction bits. Flooring by 2^H
    // first and by 255 later gives the same floor as one division.
    logic [HUE_BITS+15:0] xq_prod, xt_prod;
    logic [15:0]          s3_yq_reg, s3_yq_next, s3_yt_reg, s3_yt_next;
    sector_t              s3_sector_reg;
    logic [7:0]           s3_bri_reg;
    logic [15:0]          s3_pprod_reg;

    always_comb begin
        xq_prod    = {{(HUE_BITS+8){1'b0}}, s2_bri_reg} * {8'b0, s2_nq_reg};
        xt_prod    = {{(HUE_BITS+8){1'b0}}, s2_bri_reg} * {8'b0, s2_nt_reg};
        s3_yq_next = xq_prod[HUE_BITS+15:HUE_BITS];
        s3_yt_next = xt_prod[HUE_BITS+15:HUE_BITS];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_yq_reg     <= s3_yq_next;
            s3_yt_reg     <= s3_yt_next;
            s3_sector_reg <= s2_sector_reg;
            s3_bri_reg    <= s2_bri_reg;
            s3_pprod_reg  <= s2_pprod_reg;
        end
    end

    // Stage 4: divide the three products by 255 and order the channels.
    logic [7:0]  p_byte, q_byte, t_byte;
    logic [23:0] out_reg, out_next;

    hsvrgb_div255 u_div_p (.dividend(s3_pprod_reg), .quotient(p_byte));
    hsvrgb_div255 u_div_q (.dividend(s3_yq_reg),    .quotient(q_byte));
    hsvrgb_div255 u_div_t (.dividend(s3_yt_reg),    .quotient(t_byte));

    always_comb begin
        unique case (s3_sector_reg)
            SECT_RED_YEL: out_next = {p_byte, t_byte, s3_bri_reg};
            SECT_YEL_GRN: out_next = {p_byte, s3_bri_reg, q_byte};
            SECT_GRN_CYN: out_next = {t_byte, s3_bri_reg, p_byte};
            SECT_CYN_BLU: out_next = {s3_bri_reg, q_byte, p_byte};
            SECT_BLU_MAG: out_next = {s3_bri_reg, p_byte, t_byte};
            default:      out_next = {q_byte, p_byte, s3_bri_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

endmodule

### hdl/hsvrgb_div255.sv
`timescale 1ns / 1ps

module hsvrgb_div255
    import hsvrgb_pkg::*;
(
    input  logic [15:0] dividend,
    output logic [7:0]  quotient
);

    // Multiply by the scaled reciprocal; the quotient sits just above the shift.
    logic [31:0] scaled;

    assign scaled   = {16'b0, dividend} * {16'b0, DIV255_RECIP};
    assign quotient = scaled[DIV255_SHIFT+7:DIV255_SHIFT];

endmodule

### hdl/hsvrgb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsvrgb_checker
    import hsvrgb_pkg::*;
#(
    parameter int HUE_BITS = HUE_BITS_DEFAULT,
    localparam int IN_W    = ((HUE_BITS + 16 + 7) / 8) * 8
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [IN_W-1:0] s_tdata,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [23:0]     m_tdata
);

    logic       s_acc;
    logic [7:0] s_sat;
    logic [7:0] s_bri;

    assign s_acc = s_tvalid && s_tready;
    assign s_sat = s_tdata[HUE_BITS+7:HUE_BITS];
    assign s_bri = s_tdata[HUE_BITS+15:HUE_BITS+8];

    `ASSERT_CLK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "reset left a word")

    `ASSERT_CLK(a_ready_only_full, aclk, aresetn, !s_tready |-> (m_tvalid && !m_tready),
        "input blocked while the output was free")

    `ASSERT_CLK(a_stall_holds, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled word changed")

    // A gray word accepted out of reset, with no stall and no reset on the edges that
    // follow up to the check, is on m_tdata with every channel at its value.
    `ASSERT_CLK(a_gray_latency, aclk, aresetn,
        ($past(s_acc, 4) && $past(aresetn, 4) && $past(s_sat, 4) == 8'd0 &&
         $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3) &&
         $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3)) |->
        (m_tvalid && m_tdata[7:0] == $past(s_bri, 4) && m_tdata[15:8] == $past(s_bri, 4) &&
         m_tdata[23:16] == $past(s_bri, 4)), "gray word wrong or late")

endmodule

bind hsv_to_rgb_pixel_unit hsvrgb_checker #(.HUE_BITS(HUE_BITS)) u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

// Stream testbench for the HSV to RGB pixel converter. A queue of pixel words is
// filled up front, a clocked driver offers them on the s_ channel, and a clocked
// monitor turns every accepted input word into an expected color. It checks every
// word that leaves on the m_ channel against the oldest color still waiting.
module tb_top;
    import hsvrgb_pkg::*;

    localparam int HUE_W      = HUE_BITS_DEFAULT;
    localparam int IN_W       = ((HUE_W + 16 + 7) / 8) * 8;
    localparam int RAND_WORDS = 1500;
    localparam int MAX_GAP    = 17;
    // Long receiver hold-off, started once a few hundred results have come back.
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;

    // The packed layout matches the ports: the last field sits in the lowest bits.
    typedef struct packed {
        logic [7:0]       brightness;
        logic [7:0]       saturation;
        logic [HUE_W-1:0] hue;
    } hsv_pixel_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pixel_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [23:0]     m_tdata;

    hsv_pixel_t  pixel_q[$];    // pixels still to be offered
    rgb_pixel_t  color_q[$];    // colors expected back, oldest first
    int unsigned fail_count = 0;
    int unsigned words_out = 0;

    // Handshake outcomes of the last rising edge, read by the falling-edge drivers.
    logic        in_took = 1'b0;
    logic        out_took = 1'b0;

    int unsigned src_wait = 0;
    bit          src_burst = 1'b0;
    int unsigned sink_wait = 0;
    bit          sink_burst = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_used = 1'b0;

    hsv_to_rgb_pixel_unit #(
        .HUE_BITS(HUE_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Reset is held low from the start and then released for good.
    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Integer form of the conversion. With d = 255 * 2^H, the p, q and t bytes are
    // floor(v*(255-s)/255), floor(v*(d-f*s)/d) and floor(v*(d-(2^H-f)*s)/d).
    // The sector picks which of them lands on each channel.
    function automatic rgb_pixel_t hsv_to_rgb_expected(hsv_pixel_t px);
        logic [63:0] turn;
        logic [63:0] scaled;
        logic [63:0] frac;
        logic [63:0] den;
        logic [63:0] bri;
        logic [63:0] sat;
        logic [63:0] p_byte;
        logic [63:0] q_byte;
        logic [63:0] t_byte;
        sector_t     sector;
        rgb_pixel_t  color;
        turn   = 64'd1 << HUE_W;
        bri    = 64'(px.brightness);
        sat    = 64'(px.saturation);
        scaled = 64'(px.hue) * 64'd6;
        sector = sector_t'(3'(scaled >> HUE_W));
        frac   = scaled & (turn - 64'd1);
        den    = 64'd255 * turn;
        p_byte = bri * (64'd255 - sat) / 64'd255;
        q_byte = bri * (den - frac * sat) / den;
        t_byte = bri * (den - (turn - frac) * sat) / den;
        case (sector)
            SECT_RED_YEL: begin
                color.red = bri[7:0];    color.green = t_byte[7:0]; color.blue = p_byte[7:0];
            end
            SECT_YEL_GRN: begin
                color.red = q_byte[7:0]; color.green = bri[7:0];    color.blue = p_byte[7:0];
            end
            SECT_GRN_CYN: begin
                color.red = p_byte[7:0]; color.green = bri[7:0];    color.blue = t_byte[7:0];
            end
            SECT_CYN_BLU: begin
                color.red = p_byte[7:0]; color.green = q_byte[7:0]; color.blue = bri[7:0];
            end
            SECT_BLU_MAG: begin
                color.red = t_byte[7:0]; color.green = p_byte[7:0]; color.blue = bri[7:0];
            end
            default: begin
                color.red = bri[7:0];    color.green = p_byte[7:0]; color.blue = q_byte[7:0];
            end
        endcase
        return color;
    endfunction

    task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned bri);
        hsv_pixel_t px;
        px.hue        = hue[HUE_W-1:0];
        px.saturation = sat[7:0];
        px.brightness = bri[7:0];
        pixel_q.push_back(px);
    endtask

    // A byte from the ends of its range most of the time, otherwise any value.
    function automatic int unsigned extreme_byte();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 254;
            3: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // A new gap for one word: runs of back-to-back words alternate with random gaps.
    function automatic int unsigned draw_gap(ref bit burst);
        if ($urandom_range(0, 63) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Sender: a word stays on the bus until it is taken, then the next one follows
    // after its own gap. Each branch of the inner chain assigns s_tvalid exactly once.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !in_took)) begin
            if (src_wait != 0) begin
                src_wait = src_wait - 1;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_tdata  <= pixel_q.pop_front();
                s_tvalid <= 1'b1;
                src_wait = draw_gap(src_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off on the result side while the sender keeps offering words,
    // so every pipeline stage fills and s_tready has to drop.
    always @(negedge aclk) begin
        if (!hold_used && words_out >= HOLD_AT) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: after each taken word it stalls for a freshly drawn number of cycles.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_took) begin
                sink_wait = draw_gap(sink_burst);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait = sink_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: accepted input words become expected colors, and accepted result
    // words are compared field by field with the oldest expected color. The push
    // comes first so a word can never be checked against an empty queue by mistake.
    always @(posedge aclk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        in_took  <= s_tvalid && s_tready;
        out_took <= m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                color_q.push_back(hsv_to_rgb_expected(hsv_pixel_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                got = rgb_pixel_t'(m_tdata);
                words_out <= words_out + 1;
                if (color_q.size() == 0) begin
                    $error("result word 0x%06h arrived with no color expected", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = color_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        fail_count = fail_count + 1;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        fail_count = fail_count + 1;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // Stimulus and end of test.
    initial begin
        int unsigned boundary;
        int          offset;
        // Directed part. First hue of each sector at full saturation and value.
        add_pixel(0, 255, 255);
        add_pixel(10923, 255, 255);
        add_pixel(21846, 255, 255);
        add_pixel(32768, 255, 255);
        add_pixel(43691, 255, 255);
        add_pixel(54614, 255, 255);
        // Last hue of each sector, ending with the largest hue just short of a full turn.
        add_pixel(10922, 200, 255);
        add_pixel(21845, 200, 255);
        add_pixel(32767, 200, 255);
        add_pixel(43690, 200, 255);
        add_pixel(54613, 200, 255);
        add_pixel(65535, 200, 255);
        // Zero saturation gives gray at the value, zero value gives black.
        add_pixel(20000, 0, 173);
        add_pixel(65535, 0, 255);
        add_pixel(40000, 255, 0);
        add_pixel(0, 0, 0);
        // Alternating bit patterns, near-extreme bytes and mid-scale bytes.
        add_pixel(16'hAAAA, 8'h55, 8'hAA);
        add_pixel(16'h5555, 8'hAA, 8'h55);
        add_pixel(5000, 1, 1);
        add_pixel(60000, 254, 254);
        add_pixel(30000, 128, 128);

        // Random part: fully random pixels, hues close to a sector boundary, and
        // saturation and value drawn from the ends of their range.
        repeat (RAND_WORDS) begin
            case ($urandom_range(0, 3))
                0: begin
                    boundary = (($urandom_range(0, 6) << HUE_W) + 5) / 6;
                    offset   = int'($urandom_range(0, 6)) - 3;
                    add_pixel(int'(boundary) + offset, $urandom_range(0, 255),
                              $urandom_range(0, 255));
                end
                1: add_pixel($urandom_range(0, 65535), extreme_byte(), extreme_byte());
                default: add_pixel($urandom_range(0, 65535), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
            endcase
        end

        @(posedge aclk);
        while (!aresetn || pixel_q.size() != 0 || s_tvalid || color_q.size() != 0) begin
            @(posedge aclk);
        end
        // Watch a little longer for stray result words after the last expected one.
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every gap and stall at maximum.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
